// ===== hdl/ptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int DEFAULT_MAX_TASKS = 16;

  localparam int IN_TDATA_W   = 48;
  localparam int IN_TUSER_W   = 3;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_TUSER_W  = 3;

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_TICK     = 3'd1,
    ACT_DISPATCH = 3'd2,
    ACT_DELETE   = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    STS_DONE    = 3'd0,
    STS_RUN     = 3'd1,
    STS_FULL    = 3'd2,
    STS_BADSLOT = 3'd3,
    STS_NONE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  runs;
  } entry_t;

endpackage

// ===== hdl/periodic_task_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_timer_table_unit
// Task table held in one entry memory; tick, dispatch and delete sweep it.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// in_*     | input     | tuser: action; tdata: tag, first delay, period, slot
// out_*    | output    | tuser: status; tdata: run tag, run slot; tlast: last
//
// Add, clear, a rejected delete and unused codes finish without a sweep.
// Tick, an accepted delete and dispatch sweep the table, and dispatch then
// passes a finish state. The single read port of the entry memory is swept
// one entry per cycle, save while a dispatch sweep pauses.
// Reset empties the table at once; no memory clearing pass is needed.
// A dispatch sweep pauses while a run result cannot enter the output stage.

module periodic_task_timer_table_unit #(
  parameter int MAX_TASKS = ptt_pkg::DEFAULT_MAX_TASKS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] task_tag, [23:8] first_delay, [39:24] repeat_period, [43:40] slot
  input  logic [ptt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] action
  input  logic [ptt_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] run_tag, [11:8] run_slot
  output logic [ptt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [ptt_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int XW    = (CNT_W > 4) ? CNT_W : 4;

  // Input fields
  logic [7:0]  in_tag;
  logic [15:0] in_delay;
  logic [15:0] in_period;
  logic [3:0]  in_slot;
  logic [2:0]  in_action;

  assign in_tag    = in_tdata[7:0];
  assign in_delay  = in_tdata[23:8];
  assign in_period = in_tdata[39:24];
  assign in_slot   = in_tdata[43:40];
  assign in_action = in_tuser[2:0];

  // Entry memory
  ptt_pkg::entry_t mem [MAX_TASKS];
  ptt_pkg::entry_t mem_q_r;
  ptt_pkg::entry_t mem_wdata;
  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic            mem_re;

  // Control and payload registers
  ptt_pkg::state_t  state_r, state_nxt;
  ptt_pkg::action_t op_r, op_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic             dv_r, dv_nxt;
  logic [IDX_W-1:0] pi_r, pi_nxt;
  logic [3:0]       slot_r, slot_nxt;

  logic             out_valid_r, out_valid_nxt;
  ptt_pkg::status_t out_status_r, out_status_nxt;
  logic [7:0]       out_tag_r, out_tag_nxt;
  logic [3:0]       out_slot_r, out_slot_nxt;
  logic             out_last_r, out_last_nxt;

  logic             pend_valid_r, pend_valid_nxt;
  logic [7:0]       pend_tag_r, pend_tag_nxt;
  logic [3:0]       pend_slot_r, pend_slot_nxt;

  logic in_fire;
  logic out_free;
  logic stall;
  logic sweep_done;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ptt_pkg::ST_IDLE) && out_free;
  assign in_fire    = in_tvalid && in_tready;
  // A run result needs the held result pushed out first; wait for room.
  assign stall      = (state_r == ptt_pkg::ST_SWEEP) && dv_r
                      && (op_r == ptt_pkg::ACT_DISPATCH) && (mem_q_r.runs != 8'd0)
                      && pend_valid_r && !out_free;
  assign sweep_done = (state_r == ptt_pkg::ST_SWEEP) && !dv_r && (rd_idx_r == count_r);
  assign mem_re     = (state_r == ptt_pkg::ST_SWEEP) && !stall && (rd_idx_r < count_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_slot_r, out_tag_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (ptt_pkg::action_t'(in_action))
            ptt_pkg::ACT_TICK:     state_nxt = ptt_pkg::ST_SWEEP;
            ptt_pkg::ACT_DISPATCH: state_nxt = ptt_pkg::ST_SWEEP;
            ptt_pkg::ACT_DELETE: begin
              if (XW'(in_slot) < XW'(count_r)) state_nxt = ptt_pkg::ST_SWEEP;
            end
            default: state_nxt = ptt_pkg::ST_IDLE;
          endcase
        end
      end
      ptt_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = (op_r == ptt_pkg::ACT_DISPATCH) ? ptt_pkg::ST_FINISH
                                                     : ptt_pkg::ST_IDLE;
        end
      end
      ptt_pkg::ST_FINISH: begin
        if (out_free) state_nxt = ptt_pkg::ST_IDLE;
      end
      default: state_nxt = ptt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    ptt_pkg::entry_t upd;
    upd            = mem_q_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    w_nxt          = w_r;
    dv_nxt         = dv_r;
    pi_nxt         = pi_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_tag_nxt   = pend_tag_r;
    pend_slot_nxt  = pend_slot_r;
    mem_we         = 1'b0;
    mem_waddr      = w_r[IDX_W-1:0];
    mem_wdata      = mem_q_r;

    case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ptt_pkg::STS_DONE;
          out_tag_nxt    = 8'd0;
          out_slot_nxt   = 4'd0;
          out_last_nxt   = 1'b1;
          op_nxt         = ptt_pkg::action_t'(in_action);
          slot_nxt       = in_slot;
          rd_idx_nxt     = '0;
          w_nxt          = '0;
          dv_nxt         = 1'b0;
          pend_valid_nxt = 1'b0;
          case (ptt_pkg::action_t'(in_action))
            ptt_pkg::ACT_ADD: begin
              if (count_r < CNT_W'(MAX_TASKS)) begin
                mem_we           = 1'b1;
                mem_waddr        = count_r[IDX_W-1:0];
                mem_wdata.tag    = in_tag;
                mem_wdata.delay  = in_delay;
                mem_wdata.period = in_period;
                mem_wdata.runs   = 8'd0;
                out_slot_nxt     = 4'(count_r);
                count_nxt        = count_r + CNT_W'(1);
              end else begin
                out_status_nxt = ptt_pkg::STS_FULL;
              end
            end
            ptt_pkg::ACT_DISPATCH: begin
              // Results come from the sweep.
              out_valid_nxt = out_valid_r && !out_tready;
            end
            ptt_pkg::ACT_DELETE: begin
              if (XW'(in_slot) < XW'(count_r)) begin
                out_slot_nxt = in_slot;
              end else begin
                out_status_nxt = ptt_pkg::STS_BADSLOT;
              end
            end
            ptt_pkg::ACT_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end

      ptt_pkg::ST_SWEEP: begin
        if (!stall) begin
          dv_nxt = mem_re;
          if (mem_re) begin
            rd_idx_nxt = rd_idx_r + CNT_W'(1);
            pi_nxt     = rd_idx_r[IDX_W-1:0];
          end
        end
        // Entries are written back compacted at w_r, never ahead of the reads.
        if (dv_r && !stall) begin
          case (op_r)
            ptt_pkg::ACT_TICK: begin
              if (mem_q_r.delay != 16'd0) begin
                upd.delay = mem_q_r.delay - 16'd1;
              end else begin
                upd.delay = mem_q_r.period;
                if (mem_q_r.runs != 8'hFF) upd.runs = mem_q_r.runs + 8'd1;
              end
              mem_we    = 1'b1;
              mem_wdata = upd;
              w_nxt     = w_r + CNT_W'(1);
            end
            ptt_pkg::ACT_DELETE: begin
              if (XW'(pi_r) != XW'(slot_r)) begin
                mem_we = 1'b1;
                w_nxt  = w_r + CNT_W'(1);
              end
            end
            ptt_pkg::ACT_DISPATCH: begin
              if (mem_q_r.runs != 8'd0) begin
                // The previous run is known not to be the last; send it on.
                if (pend_valid_r) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ptt_pkg::STS_RUN;
                  out_tag_nxt    = pend_tag_r;
                  out_slot_nxt   = pend_slot_r;
                  out_last_nxt   = 1'b0;
                end
                pend_valid_nxt = 1'b1;
                pend_tag_nxt   = mem_q_r.tag;
                pend_slot_nxt  = 4'(w_r);
                if (mem_q_r.period != 16'd0) begin
                  upd.runs  = mem_q_r.runs - 8'd1;
                  mem_we    = 1'b1;
                  mem_wdata = upd;
                  w_nxt     = w_r + CNT_W'(1);
                end
              end else begin
                mem_we = 1'b1;
                w_nxt  = w_r + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
        if (sweep_done) count_nxt = w_r;
      end

      ptt_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_status_nxt = ptt_pkg::STS_RUN;
            out_tag_nxt    = pend_tag_r;
            out_slot_nxt   = pend_slot_r;
          end else begin
            out_status_nxt = ptt_pkg::STS_NONE;
            out_tag_nxt    = 8'd0;
            out_slot_nxt   = 4'd0;
          end
        end
      end

      default: ;
    endcase
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q_r <= mem[rd_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptt_pkg::ST_IDLE;
      count_r      <= '0;
      dv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      dv_r         <= dv_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    rd_idx_r     <= rd_idx_nxt;
    w_r          <= w_nxt;
    pi_r         <= pi_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
    pend_tag_r   <= pend_tag_nxt;
    pend_slot_r  <= pend_slot_nxt;
  end

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("entry count beyond table size");

  a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptt_pkg::ST_SWEEP && dv_r) |-> (w_r <= CNT_W'(pi_r)))
    else $error("compaction write overtook the read position");

  a_pend_only_in_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r != ptt_pkg::ST_IDLE && op_r == ptt_pkg::ACT_DISPATCH))
    else $error("held run result outside a dispatch");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (sweep_done && op_r == ptt_pkg::ACT_DELETE) |=>
      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not remove exactly one entry");

endmodule
